>>> sv/motion_command_frame_parser_top_macros.svh
// Assertion macros used by the frame queue of the frame parser RTL.
// Depends on a clock named clk and an active-low reset named arst_n in scope.
`ifndef MOTION_COMMAND_FRAME_PARSER_TOP_MACROS_SVH
`define MOTION_COMMAND_FRAME_PARSER_TOP_MACROS_SVH

// Same-cycle implication, checked outside reset.
`define MCFP_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, checked outside reset.
`define MCFP_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

>>> sv/mcfp_pkg.sv
// Shared types and constants of the motion command frame parser.
// No dependencies; the top level and the front, queue and back stages import this package.
package mcfp_pkg;

	localparam int FrameLen   = 35;
	localparam int SumLen     = 34;
	localparam int QueueDepth = 2;
	localparam int CntW       = $clog2(FrameLen + 1);
	localparam int CfgIdxW    = 3;
	localparam logic [7:0] LenByte = 8'h1F;

	typedef enum logic [CfgIdxW-1:0] {
		CFG_HEADER_FIRST  = 3'd0,
		CFG_HEADER_SECOND = 3'd1,
		CFG_LINEAR_CODE   = 3'd2,
		CFG_CIRCULAR_CODE = 3'd3,
		CFG_CCW_CODE      = 3'd4
	} cfg_idx_t;

	typedef enum logic [2:0] {
		ST_LINEAR_OK   = 3'd0,
		ST_CIRCULAR_OK = 3'd1,
		ST_BAD_LENGTH  = 3'd2,
		ST_CHECKSUM    = 3'd3,
		ST_UNKNOWN_CMD = 3'd4,
		ST_BAD_QUAD    = 3'd5
	} status_t;

	typedef enum logic [1:0] {
		ACK_NONE = 2'd0,
		ACK_AA   = 2'd1,
		ACK_FF   = 2'd2
	} ack_t;

	typedef struct packed {
		logic [7:0] header_first;
		logic [7:0] header_second;
		logic [7:0] linear_code;
		logic [7:0] circular_code;
		logic [7:0] ccw_code;
	} cfg_t;

	typedef struct packed {
		logic [7:0] rx_byte;
	} rx_item_t;

	// One gathered frame: bytes 0 to 33 (index k holds byte k) and the checksum verdict.
	typedef struct packed {
		logic [SumLen-1:0][7:0] frame;
		logic                   sum_ok;
	} frame_rec_t;

	typedef struct packed {
		status_t            status;
		logic [7:0]         quadrant;
		logic               counter_clockwise;
		logic signed [31:0] start_x;
		logic signed [31:0] start_y;
		logic signed [31:0] end_x;
		logic signed [31:0] end_y;
		logic signed [31:0] arc_cx;
		logic signed [31:0] arc_cy;
		logic [15:0]        speed;
		logic [7:0]         subdivision;
		ack_t               ack_code;
	} result_t;

endpackage

>>> sv/mcfp_stream_if.sv
// Valid/ready stream channel used on the ports and between the parser stages.
// The payload type is a parameter; types come from mcfp_pkg.
interface mcfp_stream_if #(
	parameter type payload_t = logic
);
	logic     valid;
	logic     ready;
	payload_t data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

>>> sv/motion_command_frame_parser_top.sv
// Motion command frame parser, top level: configuration registers and stage wiring.
// Depends on mcfp_pkg, mcfp_stream_if, mcfp_front, mcfp_frame_queue and mcfp_back.
//
// The rx channel carries one received serial byte per beat. The parser hunts for
// the two configured header bytes, then gathers command, length, 30 payload bytes
// and a checksum, 35 bytes per frame. The result channel carries one beat per
// completed frame with a status, the unpacked coordinates, speed and subdivision,
// and an acknowledgement code. Bytes that do not complete a frame produce nothing.
// Configuration is a plain write port (cfg_we, cfg_index, cfg_data), to be written
// only while the parser is idle; the block itself does not enforce this.
// The rx channel accepts one byte every cycle, but the checksum byte of a frame
// waits for queue room. The result of a frame passes through the frame queue and
// then the decode stage, whose output register holds the result.
// When the receiver stalls, the decode stage holds its result and the queue fills;
// rx keeps taking bytes and only the checksum byte of a frame waits for queue room.
// Reset clears the hunt state, the queue and the result valid, and loads the
// register defaults: header bytes 0, linear code 1, circular code 2, ccw code 0.
module motion_command_frame_parser_top #(
	parameter int QueueDepth = mcfp_pkg::QueueDepth
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cfg_we,
	input  logic [mcfp_pkg::CfgIdxW-1:0]  cfg_index,
	input  logic [7:0]                    cfg_data,
	mcfp_stream_if.sink                   rx,
	mcfp_stream_if.source                 result
);
	import mcfp_pkg::*;

	cfg_t cfg_q;

	// Writes to indexes beyond the register list are ignored.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.header_first  <= 8'd0;
			cfg_q.header_second <= 8'd0;
			cfg_q.linear_code   <= 8'd1;
			cfg_q.circular_code <= 8'd2;
			cfg_q.ccw_code      <= 8'd0;
		end else if (cfg_we) begin
			case (cfg_idx_t'(cfg_index))
				CFG_HEADER_FIRST:  cfg_q.header_first  <= cfg_data;
				CFG_HEADER_SECOND: cfg_q.header_second <= cfg_data;
				CFG_LINEAR_CODE:   cfg_q.linear_code   <= cfg_data;
				CFG_CIRCULAR_CODE: cfg_q.circular_code <= cfg_data;
				CFG_CCW_CODE:      cfg_q.ccw_code      <= cfg_data;
				default: ;
			endcase
		end
	end

	// Front to queue, and queue to back.
	mcfp_stream_if #(.payload_t(frame_rec_t)) fq ();
	mcfp_stream_if #(.payload_t(frame_rec_t)) bq ();

	mcfp_front u_front (
		.clk    (clk),
		.arst_n (arst_n),
		.cfg    (cfg_q),
		.rx     (rx),
		.fq     (fq)
	);

	mcfp_frame_queue #(
		.Depth (QueueDepth)
	) u_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.wr     (fq),
		.rd     (bq)
	);

	mcfp_back u_back (
		.clk    (clk),
		.arst_n (arst_n),
		.cfg    (cfg_q),
		.bq     (bq),
		.result (result)
	);

endmodule

>>> sv/mcfp_front.sv
// Front stage: hunts for the header and gathers bytes into a frame record.
// Depends on mcfp_pkg and mcfp_stream_if.
module mcfp_front (
	input  logic          clk,
	input  logic          arst_n,
	input  mcfp_pkg::cfg_t cfg,
	mcfp_stream_if.sink   rx,
	mcfp_stream_if.source fq
);
	import mcfp_pkg::*;

	typedef enum logic [2:0] {
		PH_HUNT,
		PH_HDR2,
		PH_CMD,
		PH_LEN,
		PH_BODY
	} phase_t;

	phase_t                 phase_q;
	logic [CntW-1:0]        cnt_q;
	logic [7:0]             sum_q;
	logic [SumLen-1:0][7:0] sh_q;
	logic [7:0]             b;
	logic                   last;
	logic                   take;
	logic                   shift;

	assign b    = rx.data.rx_byte;
	// The checksum byte is the only one that hands a record to the queue.
	assign last = (phase_q == PH_BODY) && (cnt_q == CntW'(FrameLen - 1));
	assign rx.ready = !last || fq.ready;
	assign take = rx.valid && rx.ready;

	assign fq.valid       = take && last;
	assign fq.data.frame  = sh_q;
	assign fq.data.sum_ok = (sum_q == b);

	always_comb begin
		case (phase_q)
			PH_HUNT: shift = (b == cfg.header_first);
			PH_HDR2: shift = (b == cfg.header_second);
			PH_CMD, PH_LEN: shift = 1'b1;
			PH_BODY: shift = !last;
			default: shift = 1'b0;
		endcase
	end

	// Bytes 0 to 33 enter at the top; after 34 shifts byte k sits at index k.
	always_ff @(posedge clk) begin
		if (take && shift) begin
			sh_q <= {b, sh_q[SumLen-1:1]};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_HUNT;
			cnt_q   <= '0;
			sum_q   <= '0;
		end else if (take) begin
			case (phase_q)
				PH_HUNT: begin
					if (b == cfg.header_first) begin
						sum_q   <= b;
						cnt_q   <= CntW'(1);
						phase_q <= PH_HDR2;
					end
				end
				PH_HDR2: begin
					if (b == cfg.header_second) begin
						sum_q   <= sum_q + b;
						cnt_q   <= CntW'(2);
						phase_q <= PH_CMD;
					end else begin
						phase_q <= PH_HUNT;
					end
				end
				PH_CMD: begin
					sum_q   <= sum_q + b;
					cnt_q   <= CntW'(3);
					phase_q <= PH_LEN;
				end
				PH_LEN: begin
					sum_q   <= sum_q + b;
					cnt_q   <= CntW'(4);
					phase_q <= PH_BODY;
				end
				PH_BODY: begin
					if (last) begin
						phase_q <= PH_HUNT;
					end else begin
						sum_q <= sum_q + b;
						cnt_q <= cnt_q + CntW'(1);
					end
				end
				default: phase_q <= PH_HUNT;
			endcase
		end
	end

endmodule

>>> sv/mcfp_frame_queue.sv
// Short queue of gathered frames between the front and back stages.
// Depends on mcfp_pkg, mcfp_stream_if and the assertion macro header.
module mcfp_frame_queue #(
	parameter int Depth = mcfp_pkg::QueueDepth
) (
	input  logic          clk,
	input  logic          arst_n,
	mcfp_stream_if.sink   wr,
	mcfp_stream_if.source rd
);
	import mcfp_pkg::*;
	`include "motion_command_frame_parser_top_macros.svh"

	localparam int PtrW = (Depth > 1) ? $clog2(Depth) : 1;
	localparam int QCntW = $clog2(Depth + 1);

	frame_rec_t       mem_q [Depth];
	logic [PtrW-1:0]  wr_ptr_q;
	logic [PtrW-1:0]  rd_ptr_q;
	logic [QCntW-1:0] cnt_q;
	logic             push;
	logic             pop;

	assign wr.ready = (cnt_q != QCntW'(Depth));
	assign rd.valid = (cnt_q != '0);
	assign rd.data  = mem_q[rd_ptr_q];
	assign push     = wr.valid && wr.ready;
	assign pop      = rd.valid && rd.ready;

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= wr.data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PtrW'(Depth - 1)) ? '0 : wr_ptr_q + PtrW'(1);
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == PtrW'(Depth - 1)) ? '0 : rd_ptr_q + PtrW'(1);
			end
			if (push && !pop) begin
				cnt_q <= cnt_q + QCntW'(1);
			end else if (pop && !push) begin
				cnt_q <= cnt_q - QCntW'(1);
			end
		end
	end

	`MCFP_ASSERT_NOW(a_cnt_bound, 1'b1, cnt_q <= QCntW'(Depth), "queue count above depth")
	`MCFP_ASSERT_NEXT(a_cnt_up, push && !pop, cnt_q == $past(cnt_q) + QCntW'(1), "push lost")
	`MCFP_ASSERT_NOW(a_ptr_match, cnt_q == '0, wr_ptr_q == rd_ptr_q, "empty queue with split pointers")

endmodule

>>> sv/mcfp_back.sv
// Back stage: checks a gathered frame, unpacks its fields and holds the result.
// Depends on mcfp_pkg and mcfp_stream_if.
module mcfp_back (
	input  logic          clk,
	input  logic          arst_n,
	input  mcfp_pkg::cfg_t cfg,
	mcfp_stream_if.sink   bq,
	mcfp_stream_if.source result
);
	import mcfp_pkg::*;

	result_t                res_q;
	logic                   res_valid_q;
	result_t                dec;
	logic [SumLen-1:0][7:0] f;
	logic                   hdr_ok;
	logic                   quad_ok;
	logic                   pop;

	assign f       = bq.data.frame;
	assign hdr_ok  = (f[0] == cfg.header_first) && (f[1] == cfg.header_second);
	assign quad_ok = f[5] inside {[8'd1:8'd4]};
	assign bq.ready = !res_valid_q || result.ready;
	assign pop     = bq.valid && bq.ready;

	always_comb begin
		dec.quadrant          = f[5];
		dec.counter_clockwise = (f[6] == cfg.ccw_code);
		dec.start_x           = $signed({f[7], f[8], f[9], f[10]});
		dec.start_y           = $signed({f[11], f[12], f[13], f[14]});
		dec.end_x             = $signed({f[15], f[16], f[17], f[18]});
		dec.end_y             = $signed({f[19], f[20], f[21], f[22]});
		dec.arc_cx            = $signed({f[23], f[24], f[25], f[26]});
		dec.arc_cy            = $signed({f[27], f[28], f[29], f[30]});
		dec.speed             = {f[31], f[32]};
		dec.subdivision       = f[33];
		dec.ack_code          = ACK_NONE;
		// Linear wins when both command codes are equal.
		if (f[3] != LenByte) begin
			dec.status = ST_BAD_LENGTH;
		end else if (!bq.data.sum_ok) begin
			dec.status = ST_CHECKSUM;
		end else if (f[2] == cfg.linear_code) begin
			dec.status   = quad_ok ? ST_LINEAR_OK : ST_BAD_QUAD;
			dec.ack_code = quad_ok ? ACK_AA : ACK_FF;
		end else if (f[2] == cfg.circular_code) begin
			dec.status   = quad_ok ? ST_CIRCULAR_OK : ST_BAD_QUAD;
			dec.ack_code = quad_ok ? ACK_AA : ACK_NONE;
		end else begin
			dec.status = ST_UNKNOWN_CMD;
		end
	end

	always_ff @(posedge clk) begin
		if (pop && hdr_ok) begin
			res_q <= dec;
		end
	end

	// A frame whose held header no longer matches the registers is dropped.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (pop && hdr_ok) begin
			res_valid_q <= 1'b1;
		end else if (result.ready) begin
			res_valid_q <= 1'b0;
		end
	end

	assign result.valid = res_valid_q;
	assign result.data  = res_q;

endmodule
